### hw/rtl/lse_pkg.sv
`default_nettype none

package lse_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DATA_W      = 32;

    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_SWAP  = 3'd2,
        CMD_PRINT = 3'd3,
        CMD_NOP   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_POP_UNDER  = 2'd1,
        STS_SWAP_UNDER = 2'd2,
        STS_PUSH_OVER  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWAP_RD_TOP,
        ST_SWAP_RD_NEXT,
        ST_SWAP_WR_TOP,
        ST_SWAP_WR_NEXT,
        ST_PRINT_RD,
        ST_PRINT_OUT
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/lifo_stack_engine_unit.sv
// LIFO stack engine for a bytecode interpreter.
// Input channel: i_in_valid / o_in_stall carry one command transaction
// (i_cmd, i_push_value). Output channel: o_out_valid / i_out_stall carry
// result transactions (o_data_value, o_status, o_is_data, o_last).
// Push, pop, no-op and failed swap are decoded in the accept cycle and their
// status result appears in the next cycle, so these commands run at one per
// cycle while the output is drained. A successful swap reads the top entry,
// then the next one, then writes both back swapped, one access per cycle: the
// stack sits in one single-port-read memory. Print all emits entries top
// first, with o_last on the bottom entry; each entry is read from memory and
// then sent from the registered read data. An empty print gives no result.
// The result sits in an output register; a stall on the output holds it and
// the engine waits, raising o_in_stall, until the register can be reloaded.
// Synchronous reset empties the stack and drops any pending result; memory
// contents are not cleared since only entries below the count are ever read.
`default_nettype none

module lifo_stack_engine_unit
    import lse_pkg::*;
#(
    parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [2:0]               i_cmd,
    input  wire logic signed [DATA_W-1:0] i_push_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [DATA_W-1:0]      o_data_value,
    output logic [1:0]                    o_status,
    output logic                          o_is_data,
    output logic                          o_last
);

    localparam int AW = $clog2(STACK_DEPTH);

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_rdata;

    lse_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_data_value (o_data_value),
        .o_status     (o_status),
        .o_is_data    (o_is_data),
        .o_last       (o_last),
        .o_ram_we     (w_we),
        .o_ram_waddr  (w_waddr),
        .o_ram_wdata  (w_wdata),
        .o_ram_re     (w_re),
        .o_ram_raddr  (w_raddr),
        .i_ram_rdata  (w_rdata)
    );

    lse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re && (w_waddr == w_raddr)))
        else $error("memory read and write hit the same entry in one cycle");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (int'(w_waddr) < STACK_DEPTH))
        else $error("memory write beyond the stack depth");

    a_accept_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (!o_out_valid || !i_out_stall))
        else $error("command taken while a stalled result blocks the output");

    a_no_read_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !w_re)
        else $error("memory read issued in a command accept cycle");

endmodule

`default_nettype wire

### hw/rtl/lse_ram.sv
`default_nettype none

module lse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/lse_ctrl.sv
`default_nettype none

module lse_ctrl
    import lse_pkg::*;
#(
    parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [2:0]                       i_cmd,
    input  wire logic signed [DATA_W-1:0]         i_push_value,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [DATA_W-1:0]              o_data_value,
    output logic [1:0]                            o_status,
    output logic                                  o_is_data,
    output logic                                  o_last,
    output logic                                  o_ram_we,
    output logic [$clog2(STACK_DEPTH)-1:0]        o_ram_waddr,
    output logic [DATA_W-1:0]                     o_ram_wdata,
    output logic                                  o_ram_re,
    output logic [$clog2(STACK_DEPTH)-1:0]        o_ram_raddr,
    input  wire logic [DATA_W-1:0]                i_ram_rdata
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);
    localparam logic [CW-1:0] TWO        = CW'(2);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_idx, n_idx;
    logic [DATA_W-1:0]   r_tmp, n_tmp;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    t_status             r_out_status, n_out_status;
    logic                r_out_is_data, n_out_is_data;
    logic                r_out_last, n_out_last;
    logic                w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_tmp         <= n_tmp;
        r_out_data    <= n_out_data;
        r_out_status  <= n_out_status;
        r_out_is_data <= n_out_is_data;
        r_out_last    <= n_out_last;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_tmp         = r_tmp;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_data    = r_out_data;
        n_out_status  = r_out_status;
        n_out_is_data = r_out_is_data;
        n_out_last    = r_out_last;
        o_in_stall    = 1'b1;
        o_ram_we      = 1'b0;
        o_ram_waddr   = r_count[AW-1:0];
        o_ram_wdata   = $unsigned(i_push_value);
        o_ram_re      = 1'b0;
        o_ram_raddr   = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = !w_out_free;
                if (i_in_valid && w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_data    = '0;
                    n_out_status  = STS_OK;
                    n_out_is_data = 1'b0;
                    n_out_last    = 1'b1;
                    unique case (i_cmd)
                        CMD_PUSH: begin
                            if (r_count == FULL_COUNT) begin
                                n_out_status = STS_PUSH_OVER;
                            end else begin
                                o_ram_we = 1'b1;
                                n_count  = r_count + ONE;
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_out_status = STS_POP_UNDER;
                            end else begin
                                n_count = r_count - ONE;
                            end
                        end
                        CMD_SWAP: begin
                            if (r_count < TWO) begin
                                n_out_status = STS_SWAP_UNDER;
                            end else begin
                                n_out_valid = r_out_valid && i_out_stall;
                                n_state     = ST_SWAP_RD_TOP;
                            end
                        end
                        CMD_PRINT: begin
                            n_out_valid = r_out_valid && i_out_stall;
                            if (r_count != '0) begin
                                n_idx   = AW'(r_count - ONE);
                                n_state = ST_PRINT_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWAP_RD_TOP: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = AW'(r_count - ONE);
                n_state     = ST_SWAP_RD_NEXT;
            end
            ST_SWAP_RD_NEXT: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = AW'(r_count - TWO);
                n_tmp       = i_ram_rdata;
                n_state     = ST_SWAP_WR_TOP;
            end
            ST_SWAP_WR_TOP: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = AW'(r_count - ONE);
                o_ram_wdata = i_ram_rdata;
                n_state     = ST_SWAP_WR_NEXT;
            end
            ST_SWAP_WR_NEXT: begin
                o_ram_waddr = AW'(r_count - TWO);
                o_ram_wdata = r_tmp;
                if (w_out_free) begin
                    o_ram_we      = 1'b1;
                    n_out_valid   = 1'b1;
                    n_out_data    = '0;
                    n_out_status  = STS_OK;
                    n_out_is_data = 1'b0;
                    n_out_last    = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_PRINT_RD: begin
                o_ram_re = 1'b1;
                n_state  = ST_PRINT_OUT;
            end
            ST_PRINT_OUT: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_data    = i_ram_rdata;
                    n_out_status  = STS_OK;
                    n_out_is_data = 1'b1;
                    n_out_last    = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = ST_PRINT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_value = $signed(r_out_data);
    assign o_status     = r_out_status;
    assign o_is_data    = r_out_is_data;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire
